FILE: sv/mfs_pkg.sv
// Shared types and constants of the perceptron forward-pass block.
package mfs_pkg;

    typedef enum logic [1:0] {
        CMD_WEIGHT = 2'd0,
        CMD_BIAS   = 2'd1,
        CMD_ACT    = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_WEIGHT = 2'd0,
        OP_BIAS   = 2'd1,
        OP_ACT    = 2'd2
    } op_t;

    localparam logic [2:0] REG_STAGES  = 3'd0;
    localparam logic [2:0] REG_WIDTH_0 = 3'd1;
    localparam logic [2:0] REG_WIDTH_1 = 3'd2;
    localparam logic [2:0] REG_WIDTH_2 = 3'd3;
    localparam logic [2:0] REG_WIDTH_3 = 3'd4;

    localparam int SQ_LIMIT = 16384;
    localparam int SQ_HALF  = 2048;
    localparam int SQ_ONE   = 4096;

    typedef struct packed {
        op_t                kind;
        logic               store;
        logic [1:0]         stage;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [15:0] value;
        logic               last;
    } q_entry_t;

    typedef struct packed {
        logic       valid;
        q_entry_t   entry;
    } q_head_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } back_stat_t;

    typedef struct packed {
        logic [1:0] stages;
        logic [4:0] width_0;
        logic [4:0] width_1;
        logic [4:0] width_2;
        logic [4:0] width_3;
    } cfg_t;

endpackage

FILE: sv/mfs_if.sv
// Input item and result channel interfaces.
interface mfs_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [1:0]         stage;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [15:0] value;
    logic               last;

    modport source (output valid, cmd, stage, row, col, value, last, input ready);
    modport sink   (input valid, cmd, stage, row, col, value, last, output ready);
endinterface

interface mfs_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  neuron;
    logic [12:0] activation;
    logic        final_res;

    modport source (output valid, neuron, activation, final_res, input ready);
    modport sink   (input valid, neuron, activation, final_res, output ready);
endinterface

FILE: sv/mfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 768,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

FILE: sv/mfs_front.sv
// Front end: accept items, drop ignored ones, classify and queue the rest.
module mfs_front
    import mfs_pkg::*;
#(
    parameter int MAX_WIDTH  = 16,
    parameter int MAX_STAGES = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    mfs_in_if.sink       items,
    input  back_stat_t   stat,
    output q_head_t      head
);

    q_entry_t   q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       take;
    logic       keep;
    q_entry_t   ent;

    assign items.ready = !stat.clearing && (cnt_reg != 2'd2);
    assign take        = items.valid && items.ready;

    always_comb
    begin
        ent.stage = items.stage;
        ent.row   = items.row;
        ent.col   = items.col;
        ent.value = items.value;
        ent.last  = items.last;
        ent.store = 1'b0;
        ent.kind  = OP_ACT;
        keep      = 1'b0;
        case (cmd_t'(items.cmd))
            CMD_WEIGHT:
            begin
                ent.kind = OP_WEIGHT;
                keep = (32'(items.stage) < MAX_STAGES) && (32'(items.row) < MAX_WIDTH)
                    && (32'(items.col) < MAX_WIDTH);
            end
            CMD_BIAS:
            begin
                ent.kind = OP_BIAS;
                keep = (32'(items.stage) < MAX_STAGES) && (32'(items.row) < MAX_WIDTH);
            end
            CMD_ACT:
            begin
                ent.kind  = OP_ACT;
                ent.store = 32'(items.col) < MAX_WIDTH;
                keep      = ent.store || items.last;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (take && keep)
            begin
                q_reg[wr_reg] <= ent;
                wr_reg <= !wr_reg;
            end
            if (stat.pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + 2'(take && keep) - 2'(stat.pop);
        end
    end

    assign head.valid = cnt_reg != 2'd0;
    assign head.entry = q_reg[rd_reg];

endmodule

FILE: sv/mfs_squash.sv
// Iterative squashing unit: x/(4+|x|)+0.5 by restoring division.
module mfs_squash
    import mfs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] x,
    output logic               done,
    output logic [12:0]        res
);

    logic        busy_reg;
    logic        neg_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] den_reg;
    logic [15:0] rem_reg;
    logic [12:0] num_reg;
    logic [12:0] q_reg;
    logic        done_reg;
    logic [12:0] res_reg;

    logic [14:0] mag;
    logic [15:0] den;
    logic [26:0] num;
    logic [16:0] trial;
    logic        fit;
    logic [12:0] q_next;

    assign mag    = x[15] ? 15'(-32'(x)) : 15'(x);
    assign den    = 16'(SQ_LIMIT) + 16'(mag);
    assign num    = {mag, 12'd0} + 27'(den >> 1);
    assign trial  = {rem_reg, num_reg[12]};
    assign fit    = trial >= 17'(den_reg);
    assign q_next = {q_reg[11:0], fit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (32'(x) > SQ_LIMIT)
                begin
                    res_reg  <= 13'(SQ_ONE);
                    done_reg <= 1'b1;
                end
                else if (32'(x) < -SQ_LIMIT)
                begin
                    res_reg  <= 13'd0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                    neg_reg  <= x[15];
                    den_reg  <= den;
                    rem_reg  <= 16'(num[26:13]);
                    num_reg  <= num[12:0];
                    q_reg    <= 13'd0;
                    cnt_reg  <= 4'd13;
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= fit ? 16'(trial - 17'(den_reg)) : trial[15:0];
                num_reg <= {num_reg[11:0], 1'b0};
                q_reg   <= q_next;
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    res_reg  <= neg_reg ? 13'(SQ_HALF) - q_next : 13'(SQ_HALF) + q_next;
                end
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

FILE: sv/mfs_back.sv
// Back end: store loads, clear the stores, and run the layer evaluation.
module mfs_back
    import mfs_pkg::*;
#(
    parameter int MAX_WIDTH  = 16,
    parameter int MAX_STAGES = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  q_head_t      head,
    output back_stat_t   stat,
    mfs_out_if.source    results
);

    localparam int WDEPTH = MAX_STAGES * MAX_WIDTH * MAX_WIDTH;
    localparam int BDEPTH = MAX_STAGES * MAX_WIDTH;
    localparam int WA     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
    localparam int BA     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int IW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int SW     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int NW     = $clog2(MAX_STAGES + 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_BIAS,
        S_MAC,
        S_DRAIN,
        S_SQ,
        S_SQW,
        S_WB
    } state_t;

    state_t             state_reg;
    logic [WA-1:0]      clr_reg;
    logic [SW-1:0]      s_reg;
    logic [IW-1:0]      j_reg;
    logic [IW-1:0]      k_reg;
    logic [CW-1:0]      wi_reg;
    logic [CW-1:0]      wo_reg;
    logic [NW-1:0]      nst_reg;
    logic signed [39:0] acc_reg;
    logic signed [15:0] a_reg;
    logic signed [31:0] prod_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic signed [15:0] x_reg;
    logic [12:0]        res_reg;
    logic signed [15:0] act_a_reg [MAX_WIDTH];
    logic signed [15:0] buf0_reg [MAX_WIDTH];
    logic signed [15:0] buf1_reg [MAX_WIDTH];
    logic               out_valid_reg;
    logic [3:0]         out_neuron_reg;
    logic [12:0]        out_act_reg;
    logic               out_final_reg;

    logic               pop;
    logic               w_we;
    logic [WA-1:0]      w_waddr;
    logic [WA-1:0]      w_raddr;
    logic [15:0]        w_rdata;
    logic               b_we;
    logic [BA-1:0]      b_waddr;
    logic [BA-1:0]      b_raddr;
    logic [15:0]        b_rdata;
    logic signed [15:0] cur;
    logic signed [27:0] q_floor;
    logic signed [15:0] x_sat;
    logic               sq_done;
    logic [12:0]        sq_res;
    logic               last_stage;
    logic               out_free;
    logic [NW-1:0]      nst;

    function automatic logic [CW-1:0] eff_width(input logic [4:0] r);
        if (r == 5'd0)
        begin
            return CW'(1);
        end
        if (32'(r) > MAX_WIDTH)
        begin
            return CW'(MAX_WIDTH);
        end
        return CW'(r);
    endfunction

    function automatic logic [CW-1:0] layer_width(input int k);
        case (k)
            0:       return eff_width(cfg.width_0);
            1:       return eff_width(cfg.width_1);
            2:       return eff_width(cfg.width_2);
            default: return eff_width(cfg.width_3);
        endcase
    endfunction

    always_comb
    begin
        if (cfg.stages == 2'd0)
        begin
            nst = NW'(1);
        end
        else if (32'(cfg.stages) > MAX_STAGES)
        begin
            nst = NW'(MAX_STAGES);
        end
        else
        begin
            nst = NW'(cfg.stages);
        end
    end

    assign pop = (state_reg == S_IDLE) && head.valid;

    assign w_we    = (state_reg == S_CLEAR) || (pop && head.entry.kind == OP_WEIGHT);
    assign w_waddr = (state_reg == S_CLEAR) ? clr_reg
        : WA'((32'(head.entry.stage) * MAX_WIDTH + 32'(head.entry.row)) * MAX_WIDTH
              + 32'(head.entry.col));
    assign b_we    = ((state_reg == S_CLEAR) && (32'(clr_reg) < BDEPTH))
        || (pop && head.entry.kind == OP_BIAS);
    assign b_waddr = (state_reg == S_CLEAR) ? BA'(clr_reg)
        : BA'(32'(head.entry.stage) * MAX_WIDTH + 32'(head.entry.row));
    assign w_raddr = WA'((32'(s_reg) * MAX_WIDTH + 32'(j_reg)) * MAX_WIDTH + 32'(k_reg));
    assign b_raddr = BA'(32'(s_reg) * MAX_WIDTH + 32'(j_reg));

    mfs_ram #(.WIDTH(16), .DEPTH(WDEPTH), .AW(WA)) u_wram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata ((state_reg == S_CLEAR) ? 16'd0 : head.entry.value),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    mfs_ram #(.WIDTH(16), .DEPTH(BDEPTH), .AW(BA)) u_bram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata ((state_reg == S_CLEAR) ? 16'd0 : head.entry.value),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    always_comb
    begin
        if (s_reg == SW'(0))
        begin
            cur = act_a_reg[k_reg];
        end
        else if (s_reg[0])
        begin
            cur = buf0_reg[k_reg];
        end
        else
        begin
            cur = buf1_reg[k_reg];
        end
    end

    assign q_floor = acc_reg[39:12];
    always_comb
    begin
        if (q_floor > 28'sd32767)
        begin
            x_sat = 16'sh7FFF;
        end
        else if (q_floor < -28'sd32768)
        begin
            x_sat = -16'sh8000;
        end
        else
        begin
            x_sat = q_floor[15:0];
        end
    end

    mfs_squash u_squash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_SQ),
        .x     (x_reg),
        .done  (sq_done),
        .res   (sq_res)
    );

    assign last_stage = (32'(s_reg) + 1) == 32'(nst_reg);
    assign out_free   = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            s_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            wi_reg        <= '0;
            wo_reg        <= '0;
            nst_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                act_a_reg[i] <= '0;
            end
        end
        else
        begin
            if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            v2_reg <= v1_reg;
            v1_reg <= 1'b0;
            if (v1_reg)
            begin
                prod_reg <= $signed(w_rdata) * a_reg;
            end
            if (v2_reg)
            begin
                acc_reg <= acc_reg + 40'(prod_reg);
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + WA'(1);
                    if (32'(clr_reg) == WDEPTH - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (pop && head.entry.kind == OP_ACT)
                    begin
                        if (head.entry.store)
                        begin
                            act_a_reg[IW'(head.entry.col)] <= head.entry.value;
                        end
                        if (head.entry.last)
                        begin
                            s_reg     <= '0;
                            j_reg     <= '0;
                            wi_reg    <= layer_width(0);
                            wo_reg    <= layer_width(1);
                            nst_reg   <= nst;
                            state_reg <= S_BIAS;
                        end
                    end
                end
                S_BIAS:
                begin
                    k_reg     <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    if (k_reg == IW'(0))
                    begin
                        acc_reg <= {{12{b_rdata[15]}}, b_rdata, 12'd0};
                    end
                    a_reg  <= cur;
                    v1_reg <= 1'b1;
                    k_reg  <= k_reg + IW'(1);
                    if (32'(k_reg) + 1 == 32'(wi_reg))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        x_reg     <= x_sat;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    state_reg <= S_SQW;
                end
                S_SQW:
                begin
                    if (sq_done)
                    begin
                        res_reg   <= sq_res;
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (!last_stage || out_free)
                    begin
                        if (s_reg[0])
                        begin
                            buf1_reg[j_reg] <= $signed(16'(res_reg));
                        end
                        else
                        begin
                            buf0_reg[j_reg] <= $signed(16'(res_reg));
                        end
                        if (last_stage)
                        begin
                            out_valid_reg  <= 1'b1;
                            out_neuron_reg <= 4'(j_reg);
                            out_act_reg    <= res_reg;
                            out_final_reg  <= (32'(j_reg) + 1) == 32'(wo_reg);
                        end
                        if ((32'(j_reg) + 1) == 32'(wo_reg))
                        begin
                            j_reg <= '0;
                            if (last_stage)
                            begin
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                s_reg     <= s_reg + SW'(1);
                                wi_reg    <= wo_reg;
                                wo_reg    <= layer_width(32'(s_reg) + 2);
                                state_reg <= S_BIAS;
                            end
                        end
                        else
                        begin
                            j_reg     <= j_reg + IW'(1);
                            state_reg <= S_BIAS;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign stat.clearing      = state_reg == S_CLEAR;
    assign stat.pop           = pop;
    assign results.valid      = out_valid_reg;
    assign results.neuron     = out_neuron_reg;
    assign results.activation = out_act_reg;
    assign results.final_res  = out_final_reg;

endmodule

FILE: sv/mlp_forward_softsign.sv
// Top level of the perceptron forward-pass block with its register port.
//
// Items arrive on the items channel: weight loads, bias loads and input
// activations. A load or an activation without last is taken by the back end
// while it is idle; a two-entry queue parts the input from the back end.
// An activation with last starts an evaluation: each layer is worked through
// on the single multiply-accumulate path and the 13-step squash divider,
// one neuron at a time; a neuron whose sum lies outside the squash range
// skips the divider.
// Results leave on the results channel, one transfer per neuron of the
// final layer, final_res marking the last one.
// After reset the weight and bias stores are swept to zero, one entry per
// cycle over MAX_STAGES * MAX_WIDTH * MAX_WIDTH entries (768 by default);
// items.ready stays low meanwhile, register writes are taken. When the receiver
// stalls, the result register holds and the evaluation waits at the next neuron;
// the queue keeps taking items until it is full. The user writes registers over
// the APB-style port only while the block is idle; the block does not enforce it.
module mlp_forward_softsign
    import mfs_pkg::*;
#(
    parameter int MAX_WIDTH  = 16,
    parameter int MAX_STAGES = 3
) (
    input  logic        clk,
    input  logic        rst_n,
    mfs_in_if.sink      items,
    mfs_out_if.source   results,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg_reg;
    q_head_t    head;
    back_stat_t stat;
    logic       wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stages  <= 2'd1;
            cfg_reg.width_0 <= 5'd16;
            cfg_reg.width_1 <= 5'd16;
            cfg_reg.width_2 <= 5'd16;
            cfg_reg.width_3 <= 5'd16;
        end
        else if (wr)
        begin
            case (paddr[4:2])
                REG_STAGES:  cfg_reg.stages  <= pwdata[1:0];
                REG_WIDTH_0: cfg_reg.width_0 <= pwdata[4:0];
                REG_WIDTH_1: cfg_reg.width_1 <= pwdata[4:0];
                REG_WIDTH_2: cfg_reg.width_2 <= pwdata[4:0];
                REG_WIDTH_3: cfg_reg.width_3 <= pwdata[4:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_STAGES:  prdata = 32'(cfg_reg.stages);
            REG_WIDTH_0: prdata = 32'(cfg_reg.width_0);
            REG_WIDTH_1: prdata = 32'(cfg_reg.width_1);
            REG_WIDTH_2: prdata = 32'(cfg_reg.width_2);
            REG_WIDTH_3: prdata = 32'(cfg_reg.width_3);
            default:     prdata = 32'd0;
        endcase
    end

    mfs_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_STAGES(MAX_STAGES)) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .items (items),
        .stat  (stat),
        .head  (head)
    );

    mfs_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_STAGES(MAX_STAGES)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .head    (head),
        .stat    (stat),
        .results (results)
    );

endmodule

FILE: sv/mfs_checker.sv
// Port-level checker of the perceptron forward-pass block and its bind.
module mfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [12:0] out_act,
    input logic        out_final,
    input logic        in_ready,
    input logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_act) && $stable(out_final))
        else $error("result changed while stalled");

    a_act_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_act <= 13'd4096)
        else $error("activation above one");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    a_clear_start: assert property (@(posedge clk) $rose(rst_n) |-> !in_ready)
        else $error("items taken before clearing pass");

endmodule

bind mlp_forward_softsign mfs_checker u_mfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_act   (results.activation),
    .out_final (results.final_res),
    .in_ready  (items.ready),
    .pready    (pready)
);

FILE: tb/tb_mlp_forward_softsign.sv
// Testbench for the perceptron forward-pass block: directed table, random traffic, model check.
`timescale 1ns / 100ps
module tb_mlp_forward_softsign;
    import mfs_pkg::*;

    localparam int NW = 16;
    localparam int NS = 3;
    localparam int WATCH_LIMIT = 400000;

    typedef struct {
        cmd_t        cmd;
        logic [1:0]  stage;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [15:0] value;
        logic        last;
        int          exp_act;
    } stim_row_t;

    typedef struct {
        logic [3:0]  neuron;
        logic [12:0] activation;
        logic        final_res;
    } neuron_out_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mfs_in_if  items ();
    mfs_out_if results ();

    mlp_forward_softsign i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic signed [15:0] weights [NS*NW*NW];
    logic signed [15:0] biases [NS*NW];
    logic signed [15:0] inputs_a [NW];
    logic [1:0] cfg_stages;
    logic [4:0] cfg_width [4];

    neuron_out_t expected_outputs [$];
    stim_row_t   plan [$];
    int  error_count = 0;
    int  table_errors;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  rx_calm;
    bit  tx_calm;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    function automatic void append_expected(neuron_out_t o);
        expected_outputs.insert(expected_outputs.size(), o);
    endfunction

    function automatic void append_row(stim_row_t r);
        plan.insert(plan.size(), r);
    endfunction

    function automatic int eff_width(logic [4:0] w);
        if (w == 0)
            return 1;
        if (w > NW)
            return NW;
        return int'(w);
    endfunction

    function automatic int squash_q12(longint acc);
        longint q;
        longint mag;
        longint den;
        longint r;
        q = acc >>> 12;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        if (q > SQ_LIMIT)
            return SQ_ONE;
        if (q < -SQ_LIMIT)
            return 0;
        mag = (q < 0) ? -q : q;
        den = SQ_LIMIT + mag;
        r = (mag * 4096 + den / 2) / den;
        return (q < 0) ? int'(SQ_HALF - r) : int'(SQ_HALF + r);
    endfunction

    task automatic predict_forward_pass();
        int cur [NW];
        int nxt [NW];
        int nst;
        int wi;
        int wo;
        longint acc;
        neuron_out_t o;
        nst = (cfg_stages == 0) ? 1 : ((cfg_stages > NS) ? NS : int'(cfg_stages));
        for (int k = 0; k < NW; k++)
            cur[k] = inputs_a[k];
        wo = eff_width(cfg_width[0]);
        for (int s = 0; s < nst; s++)
        begin
            wi = wo;
            wo = eff_width(cfg_width[s+1]);
            for (int j = 0; j < wo; j++)
            begin
                acc = longint'(biases[s*NW+j]) * 4096;
                for (int k = 0; k < wi; k++)
                    acc += longint'(weights[(s*NW+j)*NW+k]) * longint'(cur[k]);
                nxt[j] = squash_q12(acc);
            end
            cur = nxt;
        end
        for (int j = 0; j < wo; j++)
        begin
            o.neuron = 4'(j);
            o.activation = 13'(cur[j]);
            o.final_res = (j + 1 == wo);
            append_expected(o);
        end
    endtask

    task automatic apply_item(stim_row_t r);
        case (r.cmd)
            CMD_WEIGHT:
                if (r.stage < NS)
                    weights[(r.stage*NW+r.row)*NW+r.col] = r.value;
            CMD_BIAS:
                if (r.stage < NS)
                    biases[r.stage*NW+r.row] = r.value;
            CMD_ACT:
            begin
                inputs_a[r.col] = r.value;
                if (r.last)
                    predict_forward_pass();
            end
            default: ;
        endcase
    endtask

    task automatic send_item(stim_row_t r);
        if (!rx_calm && $urandom_range(0, 3) == 0)
        begin
            items.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        items.valid <= 1'b1;
        items.cmd   <= r.cmd;
        items.stage <= r.stage;
        items.row   <= r.row;
        items.col   <= r.col;
        items.value <= r.value;
        items.last  <= r.last;
        do
            @(posedge clk);
        while (!items.ready);
        apply_item(r);
        if (r.exp_act >= 0 && expected_outputs.size() > 0
            && expected_outputs[$].activation != r.exp_act)
        begin
            $error("table activation: expected %0d, model %0d", r.exp_act,
                   expected_outputs[$].activation);
            table_errors++;
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [4:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {27'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == REG_STAGES)
            cfg_stages = val[1:0];
        else
            cfg_width[idx-1] = val;
    endtask

    task automatic drain_and_settle();
        items.valid <= 1'b0;
        while (expected_outputs.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic stim_row_t make_row(cmd_t c, int st, int rw, int cl, int v, bit l,
                                            int ex);
        stim_row_t r;
        r.cmd = c;
        r.stage = 2'(st);
        r.row = 4'(rw);
        r.col = 4'(cl);
        r.value = 16'(v);
        r.last = l;
        r.exp_act = ex;
        return r;
    endfunction

    function automatic stim_row_t random_row(int wmax);
        stim_row_t r;
        int pick;
        pick = $urandom_range(0, 99);
        r.stage = 2'($urandom_range(0, 2));
        r.row = 4'($urandom_range(0, wmax - 1));
        r.col = 4'($urandom_range(0, wmax - 1));
        r.value = (pick % 7 == 0) ? 16'($urandom()) : 16'($urandom_range(0, 8191) - 4096);
        r.last = 1'b0;
        r.exp_act = -1;
        if (pick < 45)
            r.cmd = CMD_WEIGHT;
        else if (pick < 60)
            r.cmd = CMD_BIAS;
        else
        begin
            r.cmd = CMD_ACT;
            r.last = (pick >= 90);
        end
        if (pick < 3)
        begin
            r.cmd = CMD_NONE;
            r.stage = 2'($urandom());
            r.row = 4'($urandom());
            r.col = 4'($urandom());
        end
        else if (pick == 3)
        begin
            r.stage = 2'd3;
            r.row = 4'($urandom());
            r.col = 4'($urandom());
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
            results.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            results.ready <= 1'b0;
        end
        else if (!tx_calm && $urandom_range(0, 15) == 0)
        begin
            stall_left <= $urandom_range(0, 13);
            results.ready <= 1'b0;
        end
        else
            results.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        neuron_out_t e;
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_outputs.size() == 0)
            begin
                $error("neuron: unexpected transfer, actual %0d", results.neuron);
                error_count++;
            end
            else
            begin
                e = expected_outputs.pop_front();
                if (results.neuron !== e.neuron)
                begin
                    $error("neuron: expected %0d, actual %0d", e.neuron, results.neuron);
                    error_count++;
                end
                if (results.activation !== e.activation)
                begin
                    $error("activation: expected %0d, actual %0d", e.activation,
                           results.activation);
                    error_count++;
                end
                if (results.final_res !== e.final_res)
                begin
                    $error("final_res: expected %0d, actual %0d", e.final_res,
                           results.final_res);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCH_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        stim_row_t r;
        int wmax;
        int got;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        items.valid = 1'b0;
        items.cmd = CMD_NONE;
        items.stage = '0;
        items.row = '0;
        items.col = '0;
        items.value = '0;
        items.last = 1'b0;
        table_errors = 0;
        rx_calm = 1'b0;
        tx_calm = 1'b0;
        foreach (weights[i]) weights[i] = 0;
        foreach (biases[i]) biases[i] = 0;
        foreach (inputs_a[i]) inputs_a[i] = 0;
        cfg_stages = 2'd1;
        foreach (cfg_width[i]) cfg_width[i] = 5'd16;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_WIDTH_0, 5'd2);
        write_reg(REG_WIDTH_1, 5'd1);
        write_reg(REG_WIDTH_2, 5'd16);
        write_reg(REG_WIDTH_3, 5'd16);
        append_row(make_row(CMD_ACT, 0, 0, 0, 16'h7fff, 1, SQ_HALF));
        append_row(make_row(CMD_BIAS, 0, 0, 0, 16'h7fff, 0, -1));
        append_row(make_row(CMD_ACT, 0, 0, 1, 0, 1, SQ_ONE));
        append_row(make_row(CMD_BIAS, 0, 0, 0, 16'h8000, 0, -1));
        append_row(make_row(CMD_ACT, 0, 0, 1, 0, 1, 0));
        append_row(make_row(CMD_BIAS, 0, 0, 0, 16'h1000, 0, -1));
        append_row(make_row(CMD_ACT, 0, 0, 0, 0, 1, -1));
        append_row(make_row(CMD_WEIGHT, 0, 0, 0, 16'h8000, 0, -1));
        append_row(make_row(CMD_WEIGHT, 0, 0, 1, 16'h7fff, 0, -1));
        append_row(make_row(CMD_ACT, 0, 0, 0, 16'h8000, 0, -1));
        append_row(make_row(CMD_ACT, 0, 0, 1, 16'h7fff, 1, -1));
        append_row(make_row(CMD_WEIGHT, 3, 15, 15, 16'h1234, 0, -1));
        append_row(make_row(CMD_BIAS, 3, 15, 0, 16'h4321, 0, -1));
        append_row(make_row(CMD_NONE, 3, 15, 15, 16'hffff, 1, -1));
        append_row(make_row(CMD_WEIGHT, 2, 15, 15, 16'h0fff, 0, -1));
        append_row(make_row(CMD_BIAS, 2, 15, 0, 16'hf000, 0, -1));
        append_row(make_row(CMD_ACT, 0, 0, 15, 16'h4000, 0, -1));
        append_row(make_row(CMD_ACT, 0, 0, 0, 16'h0800, 1, -1));
        foreach (plan[i])
            send_item(plan[i]);
        drain_and_settle();

        write_reg(REG_STAGES, 5'd3);
        write_reg(REG_WIDTH_0, 5'd16);
        write_reg(REG_WIDTH_1, 5'd16);
        write_reg(REG_WIDTH_2, 5'd16);
        write_reg(REG_WIDTH_3, 5'd16);
        send_item(make_row(CMD_ACT, 0, 0, 3, 16'h0100, 1, -1));
        drain_and_settle();
        write_reg(REG_STAGES, 5'd0);
        write_reg(REG_WIDTH_0, 5'd0);
        write_reg(REG_WIDTH_1, 5'd31);
        send_item(make_row(CMD_ACT, 0, 0, 0, 16'h0200, 1, -1));
        drain_and_settle();

        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_STAGES, 5'($urandom_range(0, 3)));
            for (int w = 0; w < 4; w++)
                write_reg(3'(REG_WIDTH_0 + w),
                          (phase == 0) ? 5'd16 : 5'($urandom_range(1, 5)));
            wmax = (phase == 0) ? 16 : 6;
            if (phase == 4)
            begin
                rx_calm = 1'b1;
                tx_calm = 1'b1;
            end
            got = 0;
            while (got < 100)
            begin
                r = random_row(wmax);
                if (r.cmd == CMD_ACT && r.col == 0 && $urandom_range(0, 1))
                    r.col = 4'd15;
                send_item(r);
                if (r.cmd != CMD_NONE)
                    got++;
            end
            send_item(make_row(CMD_ACT, 0, 0, $urandom_range(0, 15), int'($urandom()), 1,
                               -1));
            drain_and_settle();
        end

        if (error_count == 0 && table_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: mlp_forward_softsign.f
sv/mfs_pkg.sv
sv/mfs_if.sv
sv/mfs_ram.sv
sv/mfs_front.sv
sv/mfs_squash.sv
sv/mfs_back.sv
sv/mlp_forward_softsign.sv
sv/mfs_checker.sv
tb/tb_mlp_forward_softsign.sv
